/* design/utf8d_pkg.sv */
// Package for the UTF-8 to UCS-4 decoder: result record type, status codes
// and the reset constant. No dependencies.
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int CODE_W = 31;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REPLACED = 2'd1,
    STATUS_BAD_LEAD = 2'd2
  } utf8d_status_t;

  // One result item as it sits in the result queue.
  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    utf8d_status_t     status;
    logic              last;
  } utf8d_result_t;

  localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 31'h0000_3000;

endpackage

/* design/utf8_to_ucs4_decoder.sv */
// Streaming UTF-8 to UCS-4 decoder: one byte in, zero to two code points out.
// Depends on utf8d_pkg.
//
// The decoder takes one byte per clock cycle while its result queue has room. Each
// accepted byte is decoded in the cycle it is accepted, and its results are written
// into a four-entry result queue, from which they are offered in order.
// A byte that interrupts a sequence and is not itself a lead byte gives two
// results; every other byte gives at most one. The input is ready whenever the
// queue has room for two results (two or fewer entries held), so with the output
// side always ready the block runs at one byte per cycle, and only a run of
// two-result bytes can stall it.
// Configuration writes are taken at any time and are meant to happen while
// the decoder is idle.
`timescale 1ns / 1ps

module utf8_to_ucs4_decoder
  import utf8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CODE_W-1:0] cfg_data,
  // Byte input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  // Result channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] code_point,
  output logic [1:0]        status,
  output logic              last
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  logic [CODE_W-1:0] replacement_code;
  logic [2:0]        bytes_left;
  logic [CODE_W-1:0] partial_code;
  logic [2:0]        bytes_left_next;
  logic [CODE_W-1:0] partial_code_next;

  // Decode of the byte as if no sequence were open.
  logic              idle_has_res;
  logic [CODE_W-1:0] idle_code;
  utf8d_status_t     idle_status;
  logic              idle_lead;
  logic [2:0]        lead_left;
  logic [4:0]        lead_bits;

  logic [1:0]        num_res;
  utf8d_result_t     res0;
  utf8d_result_t     res1;
  logic [CODE_W-1:0] cont_code;

  utf8d_result_t     queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              in_fire;
  logic              out_fire;
  logic [1:0]        push_n;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count <= QCNT_W'(QDEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;
  assign push_n    = in_fire ? num_res : 2'd0;

  always_comb begin
    idle_has_res = 1'b0;
    idle_code    = '0;
    idle_status  = STATUS_OK;
    idle_lead    = 1'b0;
    lead_left    = 3'd0;
    lead_bits    = 5'd0;
    if (!in_byte[7]) begin
      idle_has_res = 1'b1;
      idle_code    = {{(CODE_W-8){1'b0}}, in_byte};
    end else if (!in_byte[6]) begin
      // A stray continuation byte is dropped.
      idle_has_res = 1'b0;
    end else if (in_byte[7:1] == 7'h7F) begin
      idle_has_res = 1'b1;
      idle_status  = STATUS_BAD_LEAD;
    end else begin
      idle_lead = 1'b1;
      if (!in_byte[5]) begin
        lead_left = 3'd1;
        lead_bits = in_byte[4:0];
      end else if (!in_byte[4]) begin
        lead_left = 3'd2;
        lead_bits = {1'b0, in_byte[3:0]};
      end else if (!in_byte[3]) begin
        lead_left = 3'd3;
        lead_bits = {2'b0, in_byte[2:0]};
      end else if (!in_byte[2]) begin
        lead_left = 3'd4;
        lead_bits = {3'b0, in_byte[1:0]};
      end else begin
        lead_left = 3'd5;
        lead_bits = {4'b0, in_byte[0]};
      end
    end
  end

  assign cont_code = {partial_code[CODE_W-7:0], in_byte[5:0]};

  always_comb begin
    num_res           = 2'd0;
    res0              = '0;
    res1              = '0;
    bytes_left_next   = bytes_left;
    partial_code_next = partial_code;
    if (bytes_left != 3'd0 && in_byte[7:6] == 2'b10) begin
      bytes_left_next = bytes_left - 3'd1;
      if (bytes_left == 3'd1) begin
        num_res           = 2'd1;
        res0.code_point   = cont_code;
        res0.status       = STATUS_OK;
        res0.last         = 1'b1;
        partial_code_next = '0;
      end else begin
        partial_code_next = cont_code;
      end
    end else begin
      if (bytes_left != 3'd0) begin
        // The open sequence is cut short: replace it, then decode this byte afresh.
        num_res           = 2'd1;
        res0.code_point   = replacement_code;
        res0.status       = STATUS_REPLACED;
        res0.last         = !idle_has_res;
        bytes_left_next   = 3'd0;
        partial_code_next = '0;
        if (idle_has_res) begin
          num_res         = 2'd2;
          res1.code_point = idle_code;
          res1.status     = idle_status;
          res1.last       = 1'b1;
        end
      end else if (idle_has_res) begin
        num_res         = 2'd1;
        res0.code_point = idle_code;
        res0.status     = idle_status;
        res0.last       = 1'b1;
      end
      if (idle_lead) begin
        bytes_left_next   = lead_left;
        partial_code_next = {{(CODE_W-5){1'b0}}, lead_bits};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_code <= REPLACEMENT_RESET;
      bytes_left       <= 3'd0;
      partial_code     <= '0;
      wr_ptr           <= '0;
      rd_ptr           <= '0;
      count            <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        replacement_code <= cfg_data;
      end
      if (in_fire) begin
        bytes_left   <= bytes_left_next;
        partial_code <= partial_code_next;
      end
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push_n) - QCNT_W'(out_fire);
    end
  end

  // Result storage needs no reset; entries are only read once counted.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  assign code_point = queue[rd_ptr].code_point;
  assign status     = queue[rd_ptr].status;
  assign last       = queue[rd_ptr].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("result queue count exceeds its depth");

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= 3'd5)
    else $error("bytes_left outside the range of a six-byte sequence");

  a_cont_step: assert property (@(posedge clk) disable iff (rst)
    in_fire && bytes_left != 3'd0 && in_byte[7:6] == 2'b10
    |=> bytes_left == $past(bytes_left) - 3'd1)
    else $error("continuation byte did not count down bytes_left");

  a_bad_lead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_BAD_LEAD |-> code_point == '0)
    else $error("invalid lead result carries a nonzero code point");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    in_fire && num_res == 2'd2 |=> out_valid && count >= QCNT_W'(2))
    else $error("two-result item did not leave two queued results");

endmodule

/* tb/sv/utf8_to_ucs4_decoder_test.sv */
// Self-checking testbench for the UTF-8 to UCS-4 decoder: directed and random
// byte streams, with results checked against a predictor of the decoder.
// Depends on utf8d_pkg and utf8_to_ucs4_decoder.
`timescale 1ns / 1ps

module utf8_to_ucs4_decoder_test;
  import utf8d_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CODE_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] code_point;
  logic [1:0]        status;
  logic              last;

  // Predictor state.
  logic [2:0]        bytes_left_q;
  logic [CODE_W-1:0] partial_q;
  logic [CODE_W-1:0] replacement_q;
  utf8d_result_t     pending_codes[$];

  int error_count = 0;
  int useful_bytes = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  utf8_to_ucs4_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .status     (status),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
    error_count++;
  endtask

  // Decodes a byte as if no sequence were open. Returns 1 when it yields a result.
  function automatic bit decode_fresh(input logic [7:0] b, output logic [CODE_W-1:0] cp,
                                      output utf8d_status_t st);
    logic [7:0] mask;
    int len;
    cp = '0;
    st = STATUS_OK;
    if (!b[7]) begin
      cp = CODE_W'(b);
      return 1'b1;
    end
    if (!b[6]) begin
      return 1'b0;
    end
    if (b >= 8'hFE) begin
      st = STATUS_BAD_LEAD;
      return 1'b1;
    end
    mask = 8'h20;
    len = 2;
    while ((b & mask) != 8'h00) begin
      mask = mask >> 1;
      len++;
    end
    partial_q = CODE_W'(b & (mask - 8'd1));
    bytes_left_q = 3'(len - 1);
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [CODE_W-1:0] cps[2];
    utf8d_status_t sts[2];
    int n;
    n = 0;
    if (bytes_left_q != 3'd0) begin
      if (b[7:6] == 2'b10) begin
        partial_q = {partial_q[CODE_W-7:0], b[5:0]};
        bytes_left_q = bytes_left_q - 3'd1;
        if (bytes_left_q == 3'd0) begin
          cps[0] = partial_q;
          sts[0] = STATUS_OK;
          n = 1;
          partial_q = '0;
        end
      end else begin
        // The open sequence is cut short; the byte then starts afresh.
        cps[0] = replacement_q;
        sts[0] = STATUS_REPLACED;
        n = 1;
        bytes_left_q = 3'd0;
        partial_q = '0;
        if (decode_fresh(b, cps[1], sts[1])) begin
          n = 2;
        end
      end
    end else if (decode_fresh(b, cps[0], sts[0])) begin
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      pending_codes.push_back({cps[i], sts[i], i == n - 1});
    end
  endfunction

  always @(posedge clk) begin : result_check
    utf8d_result_t want;
    if (rst) begin
      bytes_left_q = 3'd0;
      partial_q = '0;
      replacement_q = REPLACEMENT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        replacement_q = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (!(bytes_left_q == 3'd0 && in_byte[7:6] == 2'b10)) begin
          useful_bytes++;
        end
        decode_byte(in_byte);
      end
      if (out_valid && out_ready) begin
        if (pending_codes.size() == 0) begin
          note_mismatch($sformatf("unexpected result code_point %h status %0d last %b",
                                  code_point, status, last));
        end else begin
          want = pending_codes.pop_front();
          if (code_point !== want.code_point) begin
            note_mismatch($sformatf("code_point got %h want %h", code_point, want.code_point));
          end
          if (status !== want.status) begin
            note_mismatch($sformatf("status got %0d want %0d", status, want.status));
          end
          if (last !== want.last) begin
            note_mismatch($sformatf("last got %b want %b for code_point %h",
                                    last, want.last, want.code_point));
          end
        end
      end
    end
  end

  // Ends the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Leaves in_valid high after the handshake so that the next item can follow
  // without a gap; whoever pauses the stream lowers it.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    // A trailing lead byte gives no result, so allow the pipeline to settle.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_replacement(input logic [CODE_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed characters, some cut short, some raw noise.
  task automatic send_random_unit();
    int pick;
    int len;
    int keep;
    logic [7:0] lead;
    logic [7:0] breaker;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(127)));
    end else if (pick < 92) begin
      len = $urandom_range(2, 6);
      lead = (8'hFF << (8 - len)) | (8'($urandom) & ((8'd1 << (7 - len)) - 8'd1));
      keep = (pick < 80) ? len - 1 : $urandom_range(len - 2);
      send_byte(lead);
      repeat (keep) send_byte({2'b10, 6'($urandom)});
      if (pick >= 80) begin
        breaker = 8'($urandom);
        if (breaker[7:6] == 2'b10) begin
          breaker[6] = 1'b1;
        end
        send_byte(breaker);
      end
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic run_random_traffic(input int goal);
    int start;
    start = useful_bytes;
    while (useful_bytes - start < goal) send_random_unit();
  endtask

  task automatic test_directed_cases();
    logic [7:0] seq[25] = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hFE, 8'hFF, 8'hC3, 8'hA9,
                            8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hC3, 8'h41,
                            8'hE2, 8'hC3, 8'hA9, 8'hE2, 8'hFE, 8'hF8, 8'h80, 8'hC0,
                            8'h00};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_replacement_extremes();
    logic [7:0] first[4] = '{8'hE2, 8'h41, 8'hF0, 8'hFF};
    logic [7:0] second[6] = '{8'hC3, 8'h7F, 8'hDF, 8'hE0, 8'h80, 8'h80};
    write_replacement({CODE_W{1'b1}});
    foreach (first[i]) send_byte(first[i]);
    write_replacement('0);
    foreach (second[i]) send_byte(second[i]);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 11;
    recv_idle_pct = 61;
    write_replacement(CODE_W'($urandom));
    run_random_traffic(290);
  endtask

  task automatic test_slow_sender();
    send_idle_pct = 61;
    recv_idle_pct = 11;
    write_replacement(CODE_W'($urandom));
    run_random_traffic(290);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_replacement(REPLACEMENT_RESET);
    run_random_traffic(250);
  endtask

  // The result side stops for a long stretch so the input stalls on a queue
  // too full for two results; then the stream pauses until all has drained.
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 80;
    repeat (40) send_random_unit();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    out_ready = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 61;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_replacement_extremes();
    test_slow_receiver();
    test_slow_sender();
    test_full_rate();
    test_result_backpressure();

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_codes.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_codes.size()));
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
